[sv/tcl_pkg.sv]
// Package for the text cursor layout engine.
// Holds widths, screen size, character codes, command and state types, font helpers.
// No dependencies.
package tcl_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 240;

  localparam int POS_W  = 9;
  localparam int WORK_W = 10;
  localparam int SUM_W  = 11;
  localparam int BYTE_W = 8;
  localparam int SIZE_W = 2;
  localparam int H_W    = 6;
  localparam int ADDR_W = 23;
  localparam int PROD_W = 16;
  localparam int MAC_W  = 24;

  localparam logic [BYTE_W-1:0] CHAR_NUL      = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_LF       = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR       = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] ASCII_BASE    = 8'h20;
  localparam logic [BYTE_W-1:0] GBK_LEAD_MIN  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_BASE     = 8'h81;
  localparam logic [BYTE_W-1:0] TRAIL_SPLIT   = 8'h7F;
  localparam logic [BYTE_W-1:0] TRAIL_BASE_LO = 8'h40;
  localparam logic [BYTE_W-1:0] TRAIL_BASE_HI = 8'h41;
  localparam logic [BYTE_W-1:0] GBK_ROW_LEN   = 8'd190;

  localparam logic [SIZE_W-1:0] SIZE_UNSUPPORTED = 2'd3;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TEXT  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CMD_ASCII = 2'd0,
    CMD_GBK   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_BOTTOM,
    S_PLACE,
    S_MUL_ROW,
    S_MUL_SCALE,
    S_COMMIT,
    S_EMIT_CLR,
    S_EMIT_GLY
  } state_t;

  // glyph height: 16 + 8 * code, so 16, 24 or 32 (40 for the unsupported code 3)
  function automatic logic [H_W-1:0] glyph_height(logic [SIZE_W-1:0] code);
    return H_W'(16) + H_W'({code, 3'b000});
  endfunction

  // bytes per GBK glyph, h*h/8
  function automatic logic [BYTE_W-1:0] glyph_bytes(logic [SIZE_W-1:0] code);
    logic [BYTE_W-1:0] v;
    case (code)
      2'd0:    v = 8'd32;
      2'd1:    v = 8'd72;
      2'd2:    v = 8'd128;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

[sv/tcl_if.sv]
// Channel interfaces of the text cursor layout engine: input, result, config.
// Depends on tcl_pkg.
interface tcl_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [tcl_pkg::POS_W-1:0]  start_x;
  logic [tcl_pkg::POS_W-1:0]  start_y;
  logic [tcl_pkg::BYTE_W-1:0] text_byte;

  modport source (output valid, kind, start_x, start_y, text_byte, input ready);
  modport sink   (input valid, kind, start_x, start_y, text_byte, output ready);
endinterface

interface tcl_out_if;
  logic                      valid;
  logic                      ready;
  tcl_pkg::cmd_t             command;
  logic [tcl_pkg::POS_W-1:0]  glyph_x;
  logic [tcl_pkg::POS_W-1:0]  glyph_y;
  logic [tcl_pkg::BYTE_W-1:0] ascii_index;
  logic [tcl_pkg::ADDR_W-1:0] font_address;
  logic                      last;

  modport source (output valid, command, glyph_x, glyph_y, ascii_index, font_address, last,
                  input ready);
  modport sink   (input valid, command, glyph_x, glyph_y, ascii_index, font_address, last,
                  output ready);
endinterface

interface tcl_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tcl_pkg::SIZE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/tcl_mac.sv]
// Shared multiply-add unit: res = a * b + c, registered, held when not enabled.
// Depends on tcl_pkg.
module tcl_mac (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tcl_pkg::PROD_W-1:0] a,
  input  logic [tcl_pkg::BYTE_W-1:0] b,
  input  logic [tcl_pkg::PROD_W-1:0] c,
  output logic [tcl_pkg::MAC_W-1:0]  res
);
  import tcl_pkg::*;

  logic [MAC_W-1:0] res_r;
  logic [MAC_W-1:0] res_nxt;

  always_comb begin
    res_nxt = MAC_W'(a) * MAC_W'(b) + MAC_W'(c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[sv/text_cursor_layout_engine.sv]
// Text cursor layout engine: one item at a time through a small sequencer.
// Start item, ignored byte, NUL or LF after CR: taken in idle, no result.
// Other text bytes: wrap, bottom check, place, optional second bottom check,
// commit, then one result per cycle while the output is not stalled; a GBK trail
// byte makes two passes through the shared multiply-add unit, then commit and its result.
// Reset (rst_n low, synchronous): cursor home, no text open, glyph height 16.
module text_cursor_layout_engine (
  input  logic      clk,
  input  logic      rst_n,
  tcl_in_if.sink    in_ch,
  tcl_out_if.source out_ch,
  tcl_cfg_if.sink   cfg_ch
);
  import tcl_pkg::*;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   size_r;
  logic [POS_W-1:0]    cur_x_r, cur_x_nxt;
  logic [POS_W-1:0]    cur_y_r, cur_y_nxt;
  logic                cr_r, cr_nxt;
  logic                lead_pend_r, lead_pend_nxt;
  logic [BYTE_W-1:0]   lead_byte_r, lead_byte_nxt;
  logic                active_r, active_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [WORK_W-1:0]   wx_r, wx_nxt;
  logic [WORK_W-1:0]   wy_r, wy_nxt;
  logic                second_r, second_nxt;
  logic                clr_pend_r, clr_pend_nxt;
  logic                gly_pend_r, gly_pend_nxt;
  cmd_t                gly_cmd_r, gly_cmd_nxt;
  logic [POS_W-1:0]    gly_x_r, gly_x_nxt;
  logic [POS_W-1:0]    gly_y_r, gly_y_nxt;
  logic [BYTE_W-1:0]   gly_idx_r, gly_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  cmd_t                out_cmd_r, out_cmd_nxt;
  logic [POS_W-1:0]    out_x_r, out_x_nxt;
  logic [POS_W-1:0]    out_y_r, out_y_nxt;
  logic [BYTE_W-1:0]   out_idx_r, out_idx_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;
  logic                out_free;

  logic                in_acc;
  logic [H_W-1:0]      h;
  logic [H_W-1:0]      h_half;
  logic [SUM_W-1:0]    wx_half_sum;
  logic [SUM_W-1:0]    wx_full_sum;
  logic [SUM_W-1:0]    wy_sum;
  logic [BYTE_W-1:0]   trail_lo;

  logic                mac_en;
  logic [PROD_W-1:0]   mac_a;
  logic [BYTE_W-1:0]   mac_b;
  logic [PROD_W-1:0]   mac_c;
  logic [MAC_W-1:0]    mac_res;

  tcl_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .res (mac_res)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign h           = glyph_height(size_r);
  assign h_half      = h >> 1;
  assign wx_half_sum = SUM_W'(wx_r) + SUM_W'(h_half);
  assign wx_full_sum = SUM_W'(wx_r) + SUM_W'(h);
  assign wy_sum      = SUM_W'(wy_r) + SUM_W'(h);
  assign trail_lo    = (byte_r < TRAIL_SPLIT) ? (byte_r - TRAIL_BASE_LO)
                                              : (byte_r - TRAIL_BASE_HI);
  assign out_free    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cr_r        <= 1'b0;
      lead_pend_r <= 1'b0;
      lead_byte_r <= '0;
      active_r    <= 1'b0;
      clr_pend_r  <= 1'b0;
      gly_pend_r  <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        size_r <= cfg_ch.data;
      end
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      cr_r        <= cr_nxt;
      lead_pend_r <= lead_pend_nxt;
      lead_byte_r <= lead_byte_nxt;
      active_r    <= active_nxt;
      clr_pend_r  <= clr_pend_nxt;
      gly_pend_r  <= gly_pend_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    wx_r      <= wx_nxt;
    wy_r      <= wy_nxt;
    gly_cmd_r <= gly_cmd_nxt;
    gly_x_r   <= gly_x_nxt;
    gly_y_r   <= gly_y_nxt;
    gly_idx_r <= gly_idx_nxt;
    if (out_load) begin
      out_cmd_r  <= out_cmd_nxt;
      out_x_r    <= out_x_nxt;
      out_y_r    <= out_y_nxt;
      out_idx_r  <= out_idx_nxt;
      out_addr_r <= out_addr_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    cr_nxt        = cr_r;
    lead_pend_nxt = lead_pend_r;
    lead_byte_nxt = lead_byte_r;
    active_nxt    = active_r;
    byte_nxt      = byte_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    second_nxt    = second_r;
    clr_pend_nxt  = clr_pend_r;
    gly_pend_nxt  = gly_pend_r;
    gly_cmd_nxt   = gly_cmd_r;
    gly_x_nxt     = gly_x_r;
    gly_y_nxt     = gly_y_r;
    gly_idx_nxt   = gly_idx_r;
    mac_en        = 1'b0;
    mac_a         = '0;
    mac_b         = '0;
    mac_c         = '0;
    out_load      = 1'b0;
    out_cmd_nxt   = CMD_CLEAR;
    out_x_nxt     = '0;
    out_y_nxt     = '0;
    out_idx_nxt   = '0;
    out_addr_nxt  = '0;
    out_last_nxt  = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == KIND_START) begin
            cur_x_nxt     = in_ch.start_x;
            cur_y_nxt     = in_ch.start_y;
            active_nxt    = 1'b1;
            lead_pend_nxt = 1'b0;
            lead_byte_nxt = '0;
            cr_nxt        = 1'b0;
          end else if (active_r && size_r != SIZE_UNSUPPORTED) begin
            byte_nxt = in_ch.text_byte;
            if (in_ch.text_byte == CHAR_NUL) begin
              active_nxt    = 1'b0;
              lead_pend_nxt = 1'b0;
              cr_nxt        = 1'b0;
            end else if (lead_pend_r) begin
              // trail byte: glyph at the cursor, then advance by h
              lead_pend_nxt = 1'b0;
              clr_pend_nxt  = 1'b0;
              gly_pend_nxt  = 1'b1;
              gly_cmd_nxt   = CMD_GBK;
              gly_x_nxt     = cur_x_r;
              gly_y_nxt     = cur_y_r;
              gly_idx_nxt   = '0;
              wx_nxt        = WORK_W'(cur_x_r) + WORK_W'(h);
              wy_nxt        = WORK_W'(cur_y_r);
              state_nxt     = S_MUL_ROW;
            end else if (in_ch.text_byte == CHAR_LF && cr_r) begin
              cr_nxt = 1'b0;
            end else begin
              cr_nxt       = 1'b0;
              wx_nxt       = WORK_W'(cur_x_r);
              wy_nxt       = WORK_W'(cur_y_r);
              second_nxt   = 1'b0;
              clr_pend_nxt = 1'b0;
              gly_pend_nxt = 1'b0;
              state_nxt    = S_WRAP;
            end
          end
        end
      end
      S_WRAP: begin
        if (wx_half_sum > SUM_W'(SCREEN_WIDTH)) begin
          wx_nxt = '0;
          wy_nxt = wy_sum[WORK_W-1:0];
        end
        state_nxt = S_BOTTOM;
      end
      S_BOTTOM: begin
        if (wy_sum > SUM_W'(SCREEN_HEIGHT)) begin
          wx_nxt       = '0;
          wy_nxt       = '0;
          clr_pend_nxt = 1'b1;
        end
        state_nxt = second_r ? S_COMMIT : S_PLACE;
      end
      S_PLACE: begin
        if (byte_r == CHAR_CR || byte_r == CHAR_LF) begin
          wx_nxt    = '0;
          wy_nxt    = wy_sum[WORK_W-1:0];
          cr_nxt    = (byte_r == CHAR_CR);
          state_nxt = S_COMMIT;
        end else if (byte_r < GBK_LEAD_MIN) begin
          if (byte_r != CHAR_SPACE) begin
            gly_pend_nxt = 1'b1;
            gly_cmd_nxt  = CMD_ASCII;
            gly_x_nxt    = wx_r[POS_W-1:0];
            gly_y_nxt    = wy_r[POS_W-1:0];
            gly_idx_nxt  = byte_r - ASCII_BASE;
          end
          wx_nxt    = wx_half_sum[WORK_W-1:0];
          state_nxt = S_COMMIT;
        end else begin
          lead_pend_nxt = 1'b1;
          lead_byte_nxt = byte_r;
          // wide glyph does not fit: wrap early and check the bottom again
          if (wx_full_sum > SUM_W'(SCREEN_WIDTH)) begin
            wx_nxt     = '0;
            wy_nxt     = wy_sum[WORK_W-1:0];
            second_nxt = 1'b1;
            state_nxt  = S_BOTTOM;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_MUL_ROW: begin
        mac_en    = 1'b1;
        mac_a     = PROD_W'(GBK_ROW_LEN);
        mac_b     = lead_byte_r - LEAD_BASE;
        mac_c     = PROD_W'(trail_lo);
        state_nxt = S_MUL_SCALE;
      end
      S_MUL_SCALE: begin
        mac_en    = 1'b1;
        mac_a     = mac_res[PROD_W-1:0];
        mac_b     = glyph_bytes(size_r);
        mac_c     = '0;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cur_x_nxt = wx_r[POS_W-1:0];
        cur_y_nxt = wy_r[POS_W-1:0];
        if (clr_pend_r) begin
          state_nxt = S_EMIT_CLR;
        end else if (gly_pend_r) begin
          state_nxt = S_EMIT_GLY;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_CLR: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_cmd_nxt  = CMD_CLEAR;
          out_last_nxt = !gly_pend_r;
          clr_pend_nxt = 1'b0;
          state_nxt    = gly_pend_r ? S_EMIT_GLY : S_IDLE;
        end
      end
      S_EMIT_GLY: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_cmd_nxt  = gly_cmd_r;
          out_x_nxt    = gly_x_r;
          out_y_nxt    = gly_y_r;
          out_idx_nxt  = gly_idx_r;
          out_addr_nxt = (gly_cmd_r == CMD_GBK) ? mac_res[ADDR_W-1:0] : '0;
          out_last_nxt = 1'b1;
          gly_pend_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.command      = out_cmd_r;
  assign out_ch.glyph_x      = out_x_r;
  assign out_ch.glyph_y      = out_y_r;
  assign out_ch.ascii_index  = out_idx_r;
  assign out_ch.font_address = out_addr_r;
  assign out_ch.last         = out_last_r;

  // a pending lead byte and a pending CR never coexist
  a_lead_cr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(lead_pend_r && cr_r))
    else $error("lead byte and CR pending together");

  // a clear that is not last is always followed by its glyph
  a_clear_then_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cmd_r == CMD_CLEAR && !out_last_r) |-> state_r == S_EMIT_GLY)
    else $error("clear without last and no glyph pending");

  // text bytes are ignored with the unsupported size code
  a_size_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == KIND_TEXT && size_r == SIZE_UNSUPPORTED)
      |=> (state_r == S_IDLE && $stable(cur_x_r) && $stable(cur_y_r)))
    else $error("text byte acted on with unsupported size");

endmodule

[sim/tb_text_cursor_layout_engine.sv]
// Self-checking testbench for text_cursor_layout_engine: directed and random text streams.
// Holds its own layout predictor in a small scoreboard class.
// Depends on tcl_pkg, the tcl_*_if interfaces and the engine RTL.
module tb_text_cursor_layout_engine;
  import tcl_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    cmd_t               command;
    logic [POS_W-1:0]   gx;
    logic [POS_W-1:0]   gy;
    logic [BYTE_W-1:0]  idx;
    logic [ADDR_W-1:0]  addr;
    logic               last;
  } draw_cmd_t;

  class layout_scoreboard;
    draw_cmd_t          expected_q[$];
    draw_cmd_t          step_cmds[2];
    int                 step_n;
    logic [SIZE_W-1:0]  size_code;
    logic [POS_W-1:0]   cur_x;
    logic [POS_W-1:0]   cur_y;
    logic               cr_seen;
    logic               lead_pend;
    logic [BYTE_W-1:0]  lead_b;
    logic               active;
    int                 mismatches;
    int                 items_noted;
    int                 results_seen;
    int                 cmd_count[3];

    function new();
      size_code    = '0;
      cur_x        = '0;
      cur_y        = '0;
      cr_seen      = 1'b0;
      lead_pend    = 1'b0;
      lead_b       = '0;
      active       = 1'b0;
      mismatches   = 0;
      items_noted  = 0;
      results_seen = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_cmd(cmd_t c, int gx, int gy, int idx, int addr);
      draw_cmd_t d;
      d.command = c;
      d.gx      = gx[POS_W-1:0];
      d.gy      = gy[POS_W-1:0];
      d.idx     = idx[BYTE_W-1:0];
      d.addr    = addr[ADDR_W-1:0];
      d.last    = 1'b0;
      step_cmds[step_n] = d;
      step_n++;
    endfunction

    function void clear_if_past_bottom(inout int x, inout int y, input int h);
      if (y + h > SCREEN_HEIGHT) begin
        x = 0;
        y = 0;
        add_cmd(CMD_CLEAR, 0, 0, 0, 0);
      end
    endfunction

    // lays out one accepted item and queues the draw commands it causes
    function void note_input(kind_t k, logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                             logic [BYTE_W-1:0] b);
      int x;
      int y;
      int h;
      int hi;
      int lo;
      items_noted++;
      step_n = 0;
      if (k == KIND_START) begin
        cur_x     = sx;
        cur_y     = sy;
        active    = 1'b1;
        lead_pend = 1'b0;
        lead_b    = '0;
        cr_seen   = 1'b0;
        return;
      end
      if (!active || size_code == SIZE_UNSUPPORTED) return;
      h = 16 + 8 * int'(size_code);
      if (b == CHAR_NUL) begin
        active    = 1'b0;
        lead_pend = 1'b0;
        cr_seen   = 1'b0;
        return;
      end
      x = int'(cur_x);
      y = int'(cur_y);
      if (lead_pend) begin
        hi = (int'(lead_b) - int'(LEAD_BASE)) & 255;
        if (b < TRAIL_SPLIT) lo = (int'(b) - int'(TRAIL_BASE_LO)) & 255;
        else lo = (int'(b) - int'(TRAIL_BASE_HI)) & 255;
        add_cmd(CMD_GBK, x, y, 0, (int'(GBK_ROW_LEN) * hi + lo) * (h * h / 8));
        x += h;
        lead_pend = 1'b0;
      end else if (b == CHAR_LF && cr_seen) begin
        cr_seen = 1'b0;  // second half of CR+LF
      end else begin
        cr_seen = 1'b0;
        if (x + h / 2 > SCREEN_WIDTH) begin
          x = 0;
          y += h;
        end
        clear_if_past_bottom(x, y, h);
        if (b == CHAR_CR || b == CHAR_LF) begin
          x = 0;
          y += h;
          cr_seen = (b == CHAR_CR);
        end else if (b < GBK_LEAD_MIN) begin
          if (b != CHAR_SPACE) add_cmd(CMD_ASCII, x, y, int'(b) - int'(ASCII_BASE), 0);
          x += h / 2;
        end else begin
          // wide glyph would cross the right edge: wrap before the lead
          if (x + h > SCREEN_WIDTH) begin
            x = 0;
            y += h;
            clear_if_past_bottom(x, y, h);
          end
          lead_pend = 1'b1;
          lead_b    = b;
        end
      end
      cur_x = x[POS_W-1:0];
      cur_y = y[POS_W-1:0];
      for (int i = 0; i < step_n; i++) begin
        step_cmds[i].last = (i == step_n - 1);
        expected_q.push_back(step_cmds[i]);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(cmd_t c, logic [POS_W-1:0] gx, logic [POS_W-1:0] gy,
                      logic [BYTE_W-1:0] idx, logic [ADDR_W-1:0] addr, logic last);
      draw_cmd_t e;
      results_seen++;
      if (c <= CMD_CLEAR) cmd_count[c]++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected command %0d at (%0d,%0d)", c, gx, gy));
        return;
      end
      e = expected_q.pop_front();
      if (c !== e.command)
        report_mismatch($sformatf("command %0d, expected %0d", c, e.command));
      if (gx !== e.gx)
        report_mismatch($sformatf("glyph_x %0d, expected %0d", gx, e.gx));
      if (gy !== e.gy)
        report_mismatch($sformatf("glyph_y %0d, expected %0d", gy, e.gy));
      if (idx !== e.idx)
        report_mismatch($sformatf("ascii_index %0d, expected %0d", idx, e.idx));
      if (addr !== e.addr)
        report_mismatch($sformatf("font_address %0d, expected %0d", addr, e.addr));
      if (last !== e.last)
        report_mismatch($sformatf("last %0b, expected %0b", last, e.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic hold_off;
  int   src_idle_pct;
  int   sink_idle_pct;

  tcl_in_if  in_ch();
  tcl_out_if out_ch();
  tcl_cfg_if cfg_ch();

  layout_scoreboard sb = new();

  text_cursor_layout_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** text_cursor_layout_engine: FAILED **");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.command, out_ch.glyph_x, out_ch.glyph_y, out_ch.ascii_index,
                      out_ch.font_address, out_ch.last);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(kind_t k, logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                           logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= k;
    in_ch.start_x   <= sx;
    in_ch.start_y   <= sy;
    in_ch.text_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(k, sx, sy, b);
    @(negedge clk);
  endtask

  task automatic send_start(int sx, int sy);
    send_item(KIND_START, sx[POS_W-1:0], sy[POS_W-1:0], BYTE_W'($urandom_range(255)));
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    send_item(KIND_TEXT, POS_W'($urandom_range(511)), POS_W'($urandom_range(511)), b);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] code);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= code;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.size_code = code;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // one piece of text: a glyph, a space, a newline, a GBK pair or a random byte
  task automatic send_piece();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      send_byte(BYTE_W'($urandom_range(8'h21, 8'h7E)));
    end else if (r < 50) begin
      send_byte(CHAR_SPACE);
    end else if (r < 55) begin
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end else if (r < 60) begin
      send_byte(($urandom_range(1) != 0) ? CHAR_CR : CHAR_LF);
    end else if (r < 88) begin
      send_byte(BYTE_W'($urandom_range(8'h81, 8'hFE)));
      if ($urandom_range(7) == 0) send_byte(BYTE_W'($urandom_range(1, 255)));
      else send_byte(BYTE_W'($urandom_range(8'h40, 8'hFE)));
    end else begin
      send_byte(BYTE_W'($urandom_range(1, 255)));
    end
  endtask

  task automatic run_random(int n);
    int target;
    int r;
    target = sb.items_noted + n;
    while (sb.items_noted < target) begin
      if ($urandom_range(99) < 8) begin
        // noise: a stray byte, possibly outside any text
        send_byte(BYTE_W'($urandom_range(255)));
      end else begin
        if ($urandom_range(9) == 0) send_start($urandom_range(511), $urandom_range(511));
        else send_start($urandom_range(SCREEN_WIDTH - 1), $urandom_range(SCREEN_HEIGHT - 1));
        repeat ($urandom_range(4, 30)) send_piece();
        r = $urandom_range(9);
        if (r < 7) begin
          send_byte(CHAR_NUL);
        end else if (r == 7) begin
          send_byte(BYTE_W'($urandom_range(8'h80, 8'hFF)));
          send_byte(CHAR_NUL);
        end else if (r == 8) begin
          send_byte(BYTE_W'($urandom_range(8'h80, 8'hFF)));
        end
      end
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] phase_size[6];
    phase_size = '{2'd1, 2'd2, 2'd0, SIZE_UNSUPPORTED, 2'd2, 2'd1};

    rst_n           = 1'b0;
    hold_off        = 1'b0;
    src_idle_pct    = 0;
    sink_idle_pct   = 0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_START;
    in_ch.start_x   = '0;
    in_ch.start_y   = '0;
    in_ch.text_byte = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_size(2'd0);
    send_start(0, 0);
    send_byte(8'h41);
    send_byte(CHAR_SPACE);
    send_byte(8'h01);            // index wraps below zero
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_LF);
    send_byte(8'h81);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(CHAR_CR);          // CR as a trail byte still pairs
    send_byte(8'h90);
    send_byte(CHAR_NUL);         // pending lead dropped
    send_byte(8'h58);            // outside a text
    send_start(511, 511);
    send_byte(8'h42);
    send_start(230, 224);
    send_byte(8'hC1);            // wide glyph wraps, then passes the bottom
    send_byte(8'h7E);
    send_byte(8'hA0);
    send_start(16, 16);
    send_byte(CHAR_CR);
    send_start(0, 32);
    send_byte(CHAR_LF);          // CR flag was dropped by the restart
    send_byte(CHAR_NUL);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_size(phase_size[p]);
      if (p < 2) begin
        src_idle_pct  = 20;
        sink_idle_pct = 71;
      end else if (p < 4) begin
        src_idle_pct  = 71;
        sink_idle_pct = 20;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      run_random((phase_size[p] == SIZE_UNSUPPORTED) ? 30 : 130);
      drain();
    end

    // long receiver stall while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    run_random(40);
    drain();

    $display("Run covered %0d input items and %0d draw commands", sb.items_noted,
             sb.results_seen);
    $display("  (%0d ascii, %0d gbk, %0d clears) over glyph heights 16/24/32 and code 3",
             sb.cmd_count[CMD_ASCII], sb.cmd_count[CMD_GBK], sb.cmd_count[CMD_CLEAR]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** text_cursor_layout_engine: PASSED **");
    end else begin
      $display("** text_cursor_layout_engine: FAILED **");
    end
    $finish;
  end

endmodule
